[hdl/kst_pkg.sv]
`timescale 1ns / 1ps
// kst_pkg: sizes, codes and word types shared by the key slot table
// depends on nothing; kst_front, kst_queue, kst_back, key_slot_table and kst_checker import it

package kst_pkg;

   localparam int SLOT_COUNT  = 16;
   localparam int SLOT_BYTES  = 64;

   localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int BYTE_W      = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
   localparam int FILL_W      = $clog2(SLOT_BYTES + 1);
   localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
   localparam int ADDR_W      = SLOT_W + BYTE_W;
   localparam int KEY_DEPTH   = 1 << ADDR_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = QPTR_W + 1;

   localparam logic [2:0] OP_ADD      = 3'd0;
   localparam logic [2:0] OP_GET      = 3'd1;
   localparam logic [2:0] OP_RELEASE  = 3'd2;
   localparam logic [2:0] OP_IS_VALID = 3'd3;
   localparam logic [2:0] OP_COUNT    = 3'd4;
   localparam logic [2:0] OP_CLEAR    = 3'd5;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd1;
   localparam logic [2:0] ST_BAD_CURVE  = 3'd2;
   localparam logic [2:0] ST_TABLE_FULL = 3'd3;
   localparam logic [2:0] ST_BAD_HANDLE = 3'd4;
   localparam logic [2:0] ST_INACTIVE   = 3'd5;

   localparam logic [1:0] CURVE_LAST_VALID = 2'd1;

   typedef enum logic [2:0] {
      CMD_ADD,
      CMD_GET,
      CMD_RELEASE,
      CMD_IS_VALID,
      CMD_COUNT,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         handle_ok;
      logic [7:0]   slot_handle;
      logic [7:0]   key_byte;
      logic         byte_last;
      logic [1:0]   curve_code;
   } cmd_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] result_handle;
      logic [7:0] out_byte;
      logic [6:0] stored_length;
      logic       stored_curve;
      logic       is_active;
      logic [7:0] active_count;
      logic       result_last;
   } rsp_type;

endpackage

[hdl/kst_req_if.sv]
`timescale 1ns / 1ps
// kst_req_if: request channel of the key slot table, valid/ready plus one word
// depends on nothing

interface kst_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [7:0] slot_handle;
   logic [7:0] key_byte;
   logic       byte_last;
   logic [1:0] curve_code;

   modport source (output valid, output opcode, output slot_handle, output key_byte,
                   output byte_last, output curve_code, input ready);
   modport sink (input valid, input opcode, input slot_handle, input key_byte,
                 input byte_last, input curve_code, output ready);
endinterface

[hdl/kst_rsp_if.sv]
`timescale 1ns / 1ps
// kst_rsp_if: response channel of the key slot table, valid/ready plus one word
// depends on nothing

interface kst_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] result_handle;
   logic [7:0] out_byte;
   logic [6:0] stored_length;
   logic       stored_curve;
   logic       is_active;
   logic [7:0] active_count;
   logic       result_last;

   modport source (output valid, output status, output result_handle, output out_byte,
                   output stored_length, output stored_curve, output is_active,
                   output active_count, output result_last, input ready);
   modport sink (input valid, input status, input result_handle, input out_byte,
                 input stored_length, input stored_curve, input is_active,
                 input active_count, input result_last, output ready);
endinterface

[hdl/kst_ram.sv]
`timescale 1ns / 1ps
// kst_ram: generic single-write, single-read RAM with registered read data
// depends on nothing

module kst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/kst_front.sv]
`timescale 1ns / 1ps
// kst_front: takes request words, decodes opcode and handle range into a command
// depends on kst_pkg and kst_req_if

module kst_front
   import kst_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   kst_req_if.sink        req,
   output logic           push_valid,
   input  logic           push_ready,
   output cmd_type        push_data
);

   logic    front_valid_ff, front_valid_in;
   cmd_type front_cmd_ff, front_cmd_in;
   logic    known;
   cmd_type decoded;

   assign req.ready = !front_valid_ff || push_ready;

   always_comb begin
      known               = 1'b1;
      decoded.kind        = CMD_ADD;
      decoded.handle_ok   = ({1'b0, req.slot_handle} < 9'(SLOT_COUNT));
      decoded.slot_handle = req.slot_handle;
      decoded.key_byte    = req.key_byte;
      decoded.byte_last   = req.byte_last;
      decoded.curve_code  = req.curve_code;
      case (req.opcode)
         OP_ADD:      decoded.kind = CMD_ADD;
         OP_GET:      decoded.kind = CMD_GET;
         OP_RELEASE:  decoded.kind = CMD_RELEASE;
         OP_IS_VALID: decoded.kind = CMD_IS_VALID;
         OP_COUNT:    decoded.kind = CMD_COUNT;
         OP_CLEAR:    decoded.kind = CMD_CLEAR;
         default:     known = 1'b0;
      endcase
   end

   always_comb begin
      front_valid_in = front_valid_ff && !push_ready;
      front_cmd_in   = front_cmd_ff;
      if (req.valid && req.ready && known) begin
         front_valid_in = 1'b1;
         front_cmd_in   = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_cmd_ff <= front_cmd_in;
   end

   assign push_valid = front_valid_ff;
   assign push_data  = front_cmd_ff;

endmodule

[hdl/kst_queue.sv]
`timescale 1ns / 1ps
// kst_queue: short command queue between the decode front and the execute back
// depends on kst_pkg

module kst_queue
   import kst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QFILL_W-1:0]   fill_ff;
   logic                 do_push, do_pop;

   assign push_ready = (fill_ff != QFILL_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + QFILL_W'(1);
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - QFILL_W'(1);
         end
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/kst_back.sv]
`timescale 1ns / 1ps
// kst_back: executes commands against the slot state and key memory, owns the
// response register; depends on kst_pkg, kst_rsp_if and kst_ram

module kst_back
   import kst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   input  cmd_type cmd,
   kst_rsp_if.source rsp
);

   typedef enum logic [1:0] {
      ST_EXEC   = 2'b01,
      ST_STREAM = 2'b10
   } state_type;

   localparam int SAT_W = (CNT_W > 8) ? CNT_W : 8;

   state_type            state_ff, state_in;
   logic [SLOT_COUNT-1:0] active_ff, active_in;
   logic [FILL_W-1:0]    length_ff [SLOT_COUNT];
   logic [FILL_W-1:0]    length_in [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] curve_ff, curve_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic                 add_busy_ff, add_busy_in;
   logic [SLOT_W-1:0]    add_slot_ff, add_slot_in;
   logic [FILL_W-1:0]    add_fill_ff, add_fill_in;
   logic                 add_long_ff, add_long_in;
   logic                 add_noslot_ff, add_noslot_in;

   logic [SLOT_W-1:0]    get_slot_ff, get_slot_in;
   logic [FILL_W-1:0]    get_len_ff, get_len_in;
   logic                 get_curve_ff, get_curve_in;
   logic [BYTE_W-1:0]    get_idx_ff, get_idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 ram_we, ram_re;
   logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [7:0]           ram_rdata;

   logic [SLOT_W-1:0]    free_idx;
   logic                 any_free;
   logic [SLOT_W-1:0]    h_idx;
   logic                 out_free;
   logic [SAT_W-1:0]     cnt_wide;
   logic [7:0]           cnt_sat;

   kst_ram #(
      .WIDTH (8),
      .DEPTH (KEY_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cmd.key_byte),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // lowest inactive slot
   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_idx = SLOT_W'(i);
            any_free = 1'b1;
         end
      end
   end

   assign h_idx    = cmd.slot_handle[SLOT_W-1:0];
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign cnt_wide = SAT_W'(cnt_ff);
   assign cnt_sat  = (cnt_wide > SAT_W'(255)) ? 8'hFF : cnt_wide[7:0];

   always_comb begin
      logic [SLOT_W-1:0] cur_slot;
      logic [FILL_W-1:0] cur_fill;
      logic              cur_long;
      logic              cur_noslot;
      rsp_type           res;

      state_in      = state_ff;
      active_in     = active_ff;
      length_in     = length_ff;
      curve_in      = curve_ff;
      cnt_in        = cnt_ff;
      add_busy_in   = add_busy_ff;
      add_slot_in   = add_slot_ff;
      add_fill_in   = add_fill_ff;
      add_long_in   = add_long_ff;
      add_noslot_in = add_noslot_ff;
      get_slot_in   = get_slot_ff;
      get_len_in    = get_len_ff;
      get_curve_in  = get_curve_ff;
      get_idx_in    = get_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_data_in   = rsp_data_ff;
      cmd_pop       = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = '0;
      ram_raddr     = '0;
      cur_slot      = add_slot_ff;
      cur_fill      = add_fill_ff;
      cur_long      = add_long_ff;
      cur_noslot    = add_noslot_ff;
      res           = '0;
      res.result_last = 1'b1;

      case (state_ff)
         ST_EXEC: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  CMD_ADD: begin
                     if (!add_busy_ff) begin
                        cur_slot   = free_idx;
                        cur_noslot = !any_free;
                        cur_fill   = '0;
                        cur_long   = 1'b0;
                     end
                     if (cur_fill < FILL_W'(SLOT_BYTES)) begin
                        ram_we    = !cur_noslot;
                        ram_waddr = {cur_slot, cur_fill[BYTE_W-1:0]};
                        cur_fill  = cur_fill + FILL_W'(1);
                     end else begin
                        cur_long = 1'b1;
                     end
                     if (cmd.byte_last) begin
                        add_busy_in   = 1'b0;
                        add_fill_in   = '0;
                        add_long_in   = 1'b0;
                        add_noslot_in = 1'b0;
                        if (cur_long) begin
                           res.status = ST_BAD_LENGTH;
                        end else if (cmd.curve_code > CURVE_LAST_VALID) begin
                           res.status = ST_BAD_CURVE;
                        end else if (cur_noslot) begin
                           res.status = ST_TABLE_FULL;
                        end else begin
                           res.status          = ST_OK;
                           res.result_handle   = 8'(cur_slot);
                           active_in[cur_slot] = 1'b1;
                           length_in[cur_slot] = cur_fill;
                           curve_in[cur_slot]  = cmd.curve_code[0];
                           cnt_in              = cnt_ff + CNT_W'(1);
                        end
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = res;
                     end else begin
                        add_busy_in   = 1'b1;
                        add_slot_in   = cur_slot;
                        add_fill_in   = cur_fill;
                        add_long_in   = cur_long;
                        add_noslot_in = cur_noslot;
                     end
                  end
                  CMD_GET: begin
                     if (!cmd.handle_ok) begin
                        res.status   = ST_BAD_HANDLE;
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = res;
                     end else if (!active_ff[h_idx]) begin
                        res.status   = ST_INACTIVE;
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = res;
                     end else begin
                        ram_re       = 1'b1;
                        ram_raddr    = {h_idx, {BYTE_W{1'b0}}};
                        get_slot_in  = h_idx;
                        get_len_in   = length_ff[h_idx];
                        get_curve_in = curve_ff[h_idx];
                        get_idx_in   = '0;
                        state_in     = ST_STREAM;
                     end
                  end
                  CMD_RELEASE: begin
                     if (!cmd.handle_ok) begin
                        res.status = ST_BAD_HANDLE;
                     end else if (!active_ff[h_idx]) begin
                        res.status = ST_INACTIVE;
                     end else begin
                        res.status       = ST_OK;
                        active_in[h_idx] = 1'b0;
                        cnt_in           = cnt_ff - CNT_W'(1);
                     end
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = res;
                  end
                  CMD_IS_VALID: begin
                     if (!cmd.handle_ok) begin
                        res.status = ST_BAD_HANDLE;
                     end else begin
                        res.status    = ST_OK;
                        res.is_active = active_ff[h_idx];
                     end
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = res;
                  end
                  CMD_COUNT: begin
                     res.status       = ST_OK;
                     res.active_count = cnt_sat;
                     rsp_valid_in     = 1'b1;
                     rsp_data_in      = res;
                  end
                  CMD_CLEAR: begin
                     active_in     = '0;
                     cnt_in        = '0;
                     add_busy_in   = 1'b0;
                     add_fill_in   = '0;
                     add_long_in   = 1'b0;
                     add_noslot_in = 1'b0;
                     res.status    = ST_OK;
                     rsp_valid_in  = 1'b1;
                     rsp_data_in   = res;
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_STREAM: begin
            if (out_free) begin
               res.status        = ST_OK;
               res.out_byte      = ram_rdata;
               res.stored_length = 7'(get_len_ff);
               res.stored_curve  = get_curve_ff;
               res.result_last   = (FILL_W'(get_idx_ff) + FILL_W'(1) == get_len_ff);
               rsp_valid_in      = 1'b1;
               rsp_data_in       = res;
               if (res.result_last) begin
                  state_in = ST_EXEC;
               end else begin
                  ram_re     = 1'b1;
                  ram_raddr  = {get_slot_ff, get_idx_ff + BYTE_W'(1)};
                  get_idx_in = get_idx_ff + BYTE_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_EXEC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_EXEC;
         active_ff     <= '0;
         cnt_ff        <= '0;
         add_busy_ff   <= 1'b0;
         add_slot_ff   <= '0;
         add_fill_ff   <= '0;
         add_long_ff   <= 1'b0;
         add_noslot_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         cnt_ff        <= cnt_in;
         add_busy_ff   <= add_busy_in;
         add_slot_ff   <= add_slot_in;
         add_fill_ff   <= add_fill_in;
         add_long_ff   <= add_long_in;
         add_noslot_ff <= add_noslot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      length_ff    <= length_in;
      curve_ff     <= curve_in;
      get_slot_ff  <= get_slot_in;
      get_len_ff   <= get_len_in;
      get_curve_ff <= get_curve_in;
      get_idx_ff   <= get_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_data_ff.status;
   assign rsp.result_handle = rsp_data_ff.result_handle;
   assign rsp.out_byte      = rsp_data_ff.out_byte;
   assign rsp.stored_length = rsp_data_ff.stored_length;
   assign rsp.stored_curve  = rsp_data_ff.stored_curve;
   assign rsp.is_active     = rsp_data_ff.is_active;
   assign rsp.active_count  = rsp_data_ff.active_count;
   assign rsp.result_last   = rsp_data_ff.result_last;

endmodule

[hdl/key_slot_table.sv]
`timescale 1ns / 1ps
// key_slot_table: top level, decode front, command queue and execute back
// depends on kst_pkg, kst_req_if, kst_rsp_if, kst_front, kst_queue, kst_back

// A table of SLOT_COUNT key slots of up to SLOT_BYTES bytes each. Request words
// pass a decode register and a two-word command queue, then an execute stage that
// handles one command per cycle while no get streams and the response register
// is free; a get then streams its key from the registered read port of the key
// memory at one word per cycle while the response side takes them. A response
// word passes the decode register, the queue and the response register, a get's
// also the read register; the queue lets the front go on taking requests while a
// response waits, until it fills. The key memory is never swept: a get only
// returns bytes that the add which activated the slot wrote, so after reset the
// table is ready at once.

module key_slot_table
   import kst_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   kst_req_if.sink   req_ch,
   kst_rsp_if.source rsp_ch
);

   logic    push_valid, push_ready;
   cmd_type push_data;
   logic    cmd_valid, cmd_pop;
   cmd_type cmd;

   kst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   kst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_pop),
      .pop_data   (cmd)
   );

   kst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp       (rsp_ch)
   );

endmodule

[hdl/kst_checker.sv]
`timescale 1ns / 1ps
// kst_checker: port-level checks of the key slot table response channel
// depends on kst_pkg; bound to key_slot_table at the end of this file

module kst_checker
   import kst_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] status,
   input logic [7:0] result_handle,
   input logic [7:0] out_byte,
   input logic [6:0] stored_length,
   input logic       is_active,
   input logic [7:0] active_count,
   input logic       result_last
);

   // stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_byte)
         && $stable(result_last))
      else $error("stalled response word changed");

   // error word ends its request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_OK |-> result_last && result_handle == 8'd0
         && out_byte == 8'd0 && stored_length == 7'd0)
      else $error("error word with payload or not last");

   // key stream words carry no query answers
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && stored_length != 7'd0 |-> status == ST_OK && !is_active
         && active_count == 8'd0 && result_handle == 8'd0)
      else $error("key stream word mixed with other answers");

   // no response right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind key_slot_table kst_checker u_kst_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .status        (rsp_ch.status),
   .result_handle (rsp_ch.result_handle),
   .out_byte      (rsp_ch.out_byte),
   .stored_length (rsp_ch.stored_length),
   .is_active     (rsp_ch.is_active),
   .active_count  (rsp_ch.active_count),
   .result_last   (rsp_ch.result_last)
);

[tb/tb_key_slot_table.sv]
`timescale 1ns / 1ps
// tb_key_slot_table: self-checking bench for the key slot table, with its own table predictor
// depends on kst_pkg, kst_req_if, kst_rsp_if and key_slot_table

module tb_key_slot_table;
   import kst_pkg::*;

   localparam logic [2:0] OP_SPARE_A      = 3'd6;
   localparam logic [2:0] OP_SPARE_B      = 3'd7;
   localparam logic [1:0] CURVE_SECP256K1 = 2'd0;
   localparam logic [1:0] CURVE_ED25519   = 2'd1;
   localparam logic [1:0] CURVE_TOP       = 2'd3;
   localparam int         STALL_LIMIT     = 2000;
   localparam int         DRAIN_CYCLES    = 16;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] slot_handle;
      logic [7:0] key_byte;
      logic       byte_last;
      logic [1:0] curve_code;
   } req_word_type;

   logic clock;
   logic reset;

   kst_req_if req_ch ();
   kst_rsp_if rsp_ch ();

   key_slot_table uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predictor copy of the table
   logic [7:0]   key_mem   [SLOT_COUNT][SLOT_BYTES];
   logic         slot_live [SLOT_COUNT];
   logic [6:0]   slot_len  [SLOT_COUNT];
   logic         slot_crv  [SLOT_COUNT];
   bit           add_open;
   int           add_slot_at;
   int           add_fill;
   bit           add_long;
   bit           add_nofree;

   rsp_type      answers_due [$];
   req_word_type cmd_backlog [$];
   req_word_type word_out;
   rsp_type      got;
   rsp_type      want;

   int send_idle;
   int recv_idle;
   int faults;
   int req_words;
   int rsp_words;
   int idle_cycles;
   int status_seen [8];

   function automatic void wipe_slot(int s);
      for (int i = 0; i < SLOT_BYTES; i++) key_mem[s][i] = 8'h00;
      slot_live[s] = 1'b0;
      slot_len[s]  = '0;
      slot_crv[s]  = 1'b0;
   endfunction

   function automatic void wipe_table();
      for (int s = 0; s < SLOT_COUNT; s++) wipe_slot(s);
      add_open    = 1'b0;
      add_slot_at = 0;
      add_fill    = 0;
      add_long    = 1'b0;
      add_nofree  = 1'b0;
   endfunction

   function automatic void post_answer(logic [2:0] st, logic [7:0] hd, logic [7:0] kb,
                                       logic [6:0] ln, logic cv, logic act,
                                       logic [7:0] cnt, logic last);
      rsp_type a;
      a.status        = st;
      a.result_handle = hd;
      a.out_byte      = kb;
      a.stored_length = ln;
      a.stored_curve  = cv;
      a.is_active     = act;
      a.active_count  = cnt;
      a.result_last   = last;
      answers_due.push_back(a);
   endfunction

   function automatic void take_key_byte(req_word_type w);
      logic [2:0] st;
      if (!add_open) begin
         add_open    = 1'b1;
         add_fill    = 0;
         add_long    = 1'b0;
         add_nofree  = 1'b1;
         add_slot_at = 0;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            if (add_nofree && !slot_live[s]) begin
               add_slot_at = s;
               add_nofree  = 1'b0;
            end
         end
      end
      if (add_fill < SLOT_BYTES) begin
         if (!add_nofree) key_mem[add_slot_at][add_fill] = w.key_byte;
         add_fill++;
      end else begin
         add_long = 1'b1;
      end
      if (w.byte_last) begin
         add_open = 1'b0;
         if (add_long) st = ST_BAD_LENGTH;
         else if (w.curve_code > CURVE_LAST_VALID) st = ST_BAD_CURVE;
         else if (add_nofree) st = ST_TABLE_FULL;
         else st = ST_OK;
         if (st == ST_OK) begin
            slot_live[add_slot_at] = 1'b1;
            slot_len[add_slot_at]  = 7'(add_fill);
            slot_crv[add_slot_at]  = w.curve_code[0];
            post_answer(ST_OK, 8'(add_slot_at), 8'h00, 7'd0, 1'b0, 1'b0, 8'h00, 1'b1);
         end else begin
            if (!add_nofree) wipe_slot(add_slot_at);
            post_answer(st, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, 8'h00, 1'b1);
         end
         add_fill   = 0;
         add_long   = 1'b0;
         add_nofree = 1'b0;
      end
   endfunction

   function automatic void run_table_command(req_word_type w);
      int  h;
      int  n;
      int  cnt;
      bit  known;
      h     = int'(w.slot_handle);
      known = h < SLOT_COUNT;
      case (w.opcode)
         OP_ADD: take_key_byte(w);
         OP_GET: begin
            if (!known) post_answer(ST_BAD_HANDLE, 0, 0, 0, 0, 0, 0, 1'b1);
            else if (!slot_live[h]) post_answer(ST_INACTIVE, 0, 0, 0, 0, 0, 0, 1'b1);
            else begin
               n = int'(slot_len[h]);
               if (n > SLOT_BYTES) n = SLOT_BYTES;
               if (n == 0) post_answer(ST_OK, 0, 0, 0, slot_crv[h], 0, 0, 1'b1);
               for (int i = 0; i < n; i++)
                  post_answer(ST_OK, 0, key_mem[h][i], 7'(n), slot_crv[h], 0, 0, i == n - 1);
            end
         end
         OP_RELEASE: begin
            if (!known) post_answer(ST_BAD_HANDLE, 0, 0, 0, 0, 0, 0, 1'b1);
            else if (!slot_live[h]) post_answer(ST_INACTIVE, 0, 0, 0, 0, 0, 0, 1'b1);
            else begin
               wipe_slot(h);
               post_answer(ST_OK, 0, 0, 0, 0, 0, 0, 1'b1);
            end
         end
         OP_IS_VALID: begin
            if (!known) post_answer(ST_BAD_HANDLE, 0, 0, 0, 0, 0, 0, 1'b1);
            else post_answer(ST_OK, 0, 0, 0, 0, slot_live[h], 0, 1'b1);
         end
         OP_COUNT: begin
            cnt = 0;
            for (int s = 0; s < SLOT_COUNT; s++) if (slot_live[s]) cnt++;
            if (cnt > 255) cnt = 255;
            post_answer(ST_OK, 0, 0, 0, 0, 0, 8'(cnt), 1'b1);
         end
         OP_CLEAR: begin
            wipe_table();
            post_answer(ST_OK, 0, 0, 0, 0, 0, 0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %0d got %0d", name, exp_v, act_v);
         faults++;
      end
   endfunction

   // stimulus builders
   function automatic void queue_word(logic [2:0] op, logic [7:0] hd, logic [7:0] kb,
                                      logic last, logic [1:0] cv);
      req_word_type w;
      w.opcode      = op;
      w.slot_handle = hd;
      w.key_byte    = kb;
      w.byte_last   = last;
      w.curve_code  = cv;
      cmd_backlog.push_back(w);
   endfunction

   function automatic void queue_query(logic [2:0] op, logic [7:0] hd);
      queue_word(op, hd, 8'($urandom), 1'($urandom), 2'($urandom));
   endfunction

   function automatic logic [7:0] random_handle();
      if ($urandom_range(9, 0) < 8) return 8'($urandom_range(SLOT_COUNT - 1, 0));
      return 8'($urandom_range(255, SLOT_COUNT));
   endfunction

   function automatic logic [1:0] random_curve();
      if ($urandom_range(9, 0) < 8) return 2'($urandom_range(CURVE_LAST_VALID, 0));
      return 2'($urandom_range(CURVE_TOP, CURVE_LAST_VALID + 1));
   endfunction

   function automatic void queue_random_query();
      int pick;
      pick = $urandom_range(99, 0);
      if (pick < 35) queue_query(OP_GET, random_handle());
      else if (pick < 55) queue_query(OP_RELEASE, random_handle());
      else if (pick < 75) queue_query(OP_IS_VALID, random_handle());
      else if (pick < 93) queue_query(OP_COUNT, random_handle());
      else queue_query(OP_CLEAR, random_handle());
   endfunction

   function automatic void queue_key(int len, logic [1:0] cv, bit mixed);
      logic last;
      for (int i = 0; i < len; i++) begin
         last = (i == len - 1);
         queue_word(OP_ADD, 8'($urandom), 8'($urandom), last, last ? cv : 2'($urandom));
         if (mixed && !last && $urandom_range(99, 0) < 8) queue_random_query();
      end
   endfunction

   // seventeen adds in a row always run into a full table
   function automatic void queue_fill();
      for (int k = 0; k <= SLOT_COUNT; k++)
         queue_key($urandom_range(2, 1), 2'($urandom_range(CURVE_LAST_VALID, 0)), 1'b0);
      queue_query(OP_COUNT, random_handle());
      queue_query(OP_RELEASE, random_handle());
      queue_query(OP_IS_VALID, random_handle());
   endfunction

   function automatic void queue_random(int budget);
      int stop;
      int pick;
      int len;
      stop = cmd_backlog.size() + budget;
      while (cmd_backlog.size() < stop) begin
         pick = $urandom_range(99, 0);
         if (pick < 40) begin
            pick = $urandom_range(99, 0);
            if (pick < 80) len = $urandom_range(8, 1);
            else if (pick < 95) len = $urandom_range(24, 9);
            else len = $urandom_range(SLOT_BYTES + 2, SLOT_BYTES - 2);
            queue_key(len, random_curve(), 1'b1);
         end else if (pick < 96) begin
            queue_random_query();
         end else begin
            queue_query(pick[0] ? OP_SPARE_A : OP_SPARE_B, random_handle());
            stop++;
         end
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            run_table_command(word_out);
            req_words++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle) begin
               word_out            = cmd_backlog.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.opcode      <= word_out.opcode;
               req_ch.slot_handle <= word_out.slot_handle;
               req_ch.key_byte    <= word_out.key_byte;
               req_ch.byte_last   <= word_out.byte_last;
               req_ch.curve_code  <= word_out.curve_code;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.status, rsp_ch.result_handle, rsp_ch.out_byte, rsp_ch.stored_length,
                    rsp_ch.stored_curve, rsp_ch.is_active, rsp_ch.active_count,
                    rsp_ch.result_last};
            rsp_words++;
            status_seen[got.status]++;
            if (answers_due.size() == 0) begin
               $error("response word with nothing outstanding, status %0d", got.status);
               faults++;
            end else begin
               want = answers_due.pop_front();
               check_field("status", 8'(want.status), 8'(got.status));
               check_field("result_handle", want.result_handle, got.result_handle);
               check_field("out_byte", want.out_byte, got.out_byte);
               check_field("stored_length", 8'(want.stored_length), 8'(got.stored_length));
               check_field("stored_curve", 8'(want.stored_curve), 8'(got.stored_curve));
               check_field("is_active", 8'(want.is_active), 8'(got.is_active));
               check_field("active_count", want.active_count, got.active_count);
               check_field("result_last", 8'(want.result_last), 8'(got.result_last));
            end
         end
         rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle);
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: %0d words still due, %0d queued", answers_due.size(),
                  cmd_backlog.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_COUNT;
      req_ch.slot_handle = 8'h00;
      req_ch.key_byte    = 8'h00;
      req_ch.byte_last   = 1'b0;
      req_ch.curve_code  = CURVE_SECP256K1;
      rsp_ch.ready       = 1'b0;
      send_idle          = 6;
      recv_idle          = 66;
      faults             = 0;
      req_words          = 0;
      rsp_words          = 0;
      idle_cycles        = 0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
      wipe_table();

      // directed opening
      queue_query(OP_COUNT, 8'd0);
      queue_word(OP_ADD, 8'd0, 8'h00, 1'b1, CURVE_SECP256K1);
      queue_word(OP_ADD, 8'hFF, 8'hFF, 1'b0, CURVE_TOP);
      queue_word(OP_ADD, 8'hFF, 8'hA5, 1'b1, CURVE_ED25519);
      queue_query(OP_GET, 8'd0);
      queue_query(OP_GET, 8'd1);
      queue_query(OP_IS_VALID, 8'd1);
      queue_query(OP_IS_VALID, 8'd7);
      queue_query(OP_IS_VALID, 8'hFF);
      queue_query(OP_GET, 8'd5);
      queue_query(OP_GET, 8'(SLOT_COUNT));
      queue_query(OP_RELEASE, 8'h80);
      queue_query(OP_RELEASE, 8'd9);
      queue_query(OP_RELEASE, 8'd0);
      queue_word(OP_ADD, 8'd0, 8'h5A, 1'b1, CURVE_LAST_VALID + 2'd1);
      queue_word(OP_ADD, 8'd0, 8'hC3, 1'b1, CURVE_TOP);
      // query in the middle of an add, then an add cut short by clear all
      queue_word(OP_ADD, 8'd0, 8'h11, 1'b0, CURVE_SECP256K1);
      queue_query(OP_COUNT, 8'd0);
      queue_word(OP_ADD, 8'd0, 8'h22, 1'b1, CURVE_ED25519);
      queue_word(OP_ADD, 8'd0, 8'h33, 1'b0, CURVE_SECP256K1);
      queue_query(OP_CLEAR, 8'd0);
      queue_query(OP_COUNT, 8'd0);
      queue_query(OP_SPARE_A, 8'd0);
      queue_query(OP_SPARE_B, 8'd0);

      queue_fill();
      queue_random(8);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0) @(negedge clock);
      send_idle = 66;
      recv_idle = 6;
      // full-size key, its readback, and one byte too many
      queue_query(OP_CLEAR, random_handle());
      queue_key(SLOT_BYTES, CURVE_ED25519, 1'b0);
      queue_query(OP_GET, 8'd0);
      queue_key(SLOT_BYTES + 1, CURVE_SECP256K1, 1'b0);
      queue_random(2);

      while (cmd_backlog.size() != 0) @(negedge clock);
      send_idle = 0;
      recv_idle = 0;
      queue_fill();
      queue_random(8);

      while (cmd_backlog.size() != 0 || req_ch.valid || answers_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request words, %0d response words over three idle mixes", req_words,
               rsp_words);
      $display("ok %0d, bad length %0d, bad curve %0d, full %0d, bad handle %0d, inactive %0d",
               status_seen[ST_OK], status_seen[ST_BAD_LENGTH], status_seen[ST_BAD_CURVE],
               status_seen[ST_TABLE_FULL], status_seen[ST_BAD_HANDLE], status_seen[ST_INACTIVE]);
      if (faults == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
